FILE: hdl/four_neighbour_weighted_smoothing_defines.svh
// Assertion macros shared by the smoothing block.
`ifndef FOUR_NEIGHBOUR_WEIGHTED_SMOOTHING_DEFINES_SVH
`define FOUR_NEIGHBOUR_WEIGHTED_SMOOTHING_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FNWS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: property failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FNWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

FILE: hdl/fnws_pkg.sv
`timescale 1ns / 1ps

package fnws_pkg;

  localparam int DEF_MAX_WIDTH        = 1024;
  localparam int DEF_WEIGHT_FRAC_BITS = 12;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int WEIGHT_W       = 16;
  localparam int CHAN_W         = 8;
  localparam int PIX_W          = 3 * CHAN_W;
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 16;

  // Output queue between the arithmetic and the master port.
  localparam int OUT_DEPTH  = 4;
  localparam int FIFO_PTR_W = $clog2(OUT_DEPTH);
  localparam int FIFO_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT     = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_WEIGHT    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOUR_WEIGHT = CFG_INDEX_W'(3);

  localparam logic [FRAME_WIDTH_W-1:0]  RST_FRAME_WIDTH      = FRAME_WIDTH_W'(1024);
  localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT     = FRAME_HEIGHT_W'(1);
  localparam logic [WEIGHT_W-1:0]       RST_CENTER_WEIGHT    = WEIGHT_W'(4096);
  localparam logic [WEIGHT_W-1:0]       RST_NEIGHBOUR_WEIGHT = WEIGHT_W'(0);

  // Pixel packing: blue in the low byte, then green, then red.
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [FRAME_WIDTH_W-1:0]  frame_width;
    logic [FRAME_HEIGHT_W-1:0] frame_height;
    logic [WEIGHT_W-1:0]       center_weight;
    logic [WEIGHT_W-1:0]       neighbour_weight;
  } cfg_t;

  // One result still to be computed: the five stencil pixels and its flags.
  typedef struct packed {
    pix_t center;
    pix_t up;
    pix_t down;
    pix_t left;
    pix_t right;
    logic last_of_run;
    logic frame_end;
  } job_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last_of_run;
    logic              frame_end;
  } result_t;

endpackage

FILE: hdl/fnws_window.sv
`timescale 1ns / 1ps
`include "four_neighbour_weighted_smoothing_defines.svh"

module fnws_window
  import fnws_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [FRAME_WIDTH_W-1:0]  frame_width,
  input  logic [FRAME_HEIGHT_W-1:0] frame_height,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  pix_t                      s_tdata,
  output logic                      job_valid,
  input  logic                      job_ready,
  output job_t                      job
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCMP_W = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;
  localparam int HCMP_W = FRAME_HEIGHT_W + 1;

  logic [COL_W-1:0]          col;
  logic [FRAME_HEIGHT_W-1:0] row;

  pix_t upper_mem [MAX_WIDTH];
  pix_t mid_mem   [MAX_WIDTH];
  pix_t rd_up;
  pix_t rd_mid;

  // Row-start captures replace the memory reads at column zero.
  pix_t row0_pix;
  pix_t row1_pix;
  pix_t row0_up;
  pix_t carry_mid;
  pix_t left_keep;
  pix_t prev_pix;
  pix_t prev2_pix;

  job_t       slot [3];
  logic [1:0] pend;

  logic              accept;
  logic              drain;
  logic [WCMP_W-1:0] w_ext;
  logic [WCMP_W-1:0] w_eff;
  logic [HCMP_W-1:0] h_eff;
  logic              last_col;
  logic              last_row;
  logic              col_zero;
  logic              col_ge2;
  logic              row_ge1;
  logic              row_ge2;
  pix_t              old_mid;
  pix_t              up_raw;
  pix_t              right_raw;
  job_t              job_a;
  job_t              job_b;
  job_t              job_c;
  logic              en_a;
  logic              en_b;
  logic              en_c;
  logic [1:0]        n_new;
  logic [COL_W-1:0]  up_addr;
  logic [COL_W-1:0]  mid_addr;

  assign accept = s_tvalid && s_tready;
  assign drain  = job_valid && job_ready;

  always_comb begin
    w_ext = WCMP_W'(frame_width);
    if (w_ext == '0) begin
      w_eff = WCMP_W'(1);
    end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (frame_height == '0) ? HCMP_W'(1) : HCMP_W'(frame_height);
  end

  assign last_col = (WCMP_W'(col) + WCMP_W'(1)) >= w_eff;
  assign last_row = (HCMP_W'(row) + HCMP_W'(1)) >= h_eff;
  assign col_zero = (col == '0);
  assign col_ge2  = (col > COL_W'(1));
  assign row_ge1  = (row != '0);
  assign row_ge2  = (row > FRAME_HEIGHT_W'(1));

  assign old_mid   = col_zero ? row0_pix : carry_mid;
  assign up_raw    = col_zero ? row0_up  : rd_up;
  assign right_raw = col_zero ? row1_pix : rd_mid;

  assign up_addr  = col + COL_W'(1);
  assign mid_addr = col + COL_W'(2);

  always_comb begin
    // Result for the pixel one row above the incoming one.
    job_a.center      = old_mid;
    job_a.up          = row_ge2 ? up_raw : old_mid;
    job_a.down        = s_tdata;
    job_a.left        = col_zero ? old_mid : left_keep;
    job_a.right       = last_col ? old_mid : right_raw;
    job_a.last_of_run = !en_b && !en_c;
    job_a.frame_end   = 1'b0;
    // Final row: result for the pixel left of the incoming one.
    job_b.center      = prev_pix;
    job_b.up          = row_ge1 ? left_keep : prev_pix;
    job_b.down        = prev_pix;
    job_b.left        = col_ge2 ? prev2_pix : prev_pix;
    job_b.right       = s_tdata;
    job_b.last_of_run = !en_c;
    job_b.frame_end   = 1'b0;
    // Final pixel of the frame gives its own result.
    job_c.center      = s_tdata;
    job_c.up          = row_ge1 ? old_mid : s_tdata;
    job_c.down        = s_tdata;
    job_c.left        = col_zero ? s_tdata : prev_pix;
    job_c.right       = s_tdata;
    job_c.last_of_run = 1'b1;
    job_c.frame_end   = 1'b1;
  end

  assign en_a  = row_ge1;
  assign en_b  = last_row && !col_zero;
  assign en_c  = last_row && last_col;
  assign n_new = {1'b0, en_a} + {1'b0, en_b} + {1'b0, en_c};

  assign s_tready  = (pend == 2'd0) || ((pend == 2'd1) && job_ready);
  assign job_valid = (pend != 2'd0);
  assign job       = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      pend <= 2'd0;
    end else begin
      if (accept) begin
        pend <= n_new;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + FRAME_HEIGHT_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end else if (drain) begin
        pend <= pend - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upper_mem[col] <= old_mid;
      mid_mem[col]   <= s_tdata;
      rd_up          <= upper_mem[up_addr];
      rd_mid         <= mid_mem[mid_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      carry_mid <= right_raw;
      left_keep <= old_mid;
      prev_pix  <= s_tdata;
      prev2_pix <= prev_pix;
      if (col_zero) begin
        row0_pix <= s_tdata;
        row0_up  <= old_mid;
      end
      if (col == COL_W'(1)) begin
        row1_pix <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[0] <= en_a ? job_a : (en_b ? job_b : job_c);
      slot[1] <= (en_a && en_b) ? job_b : job_c;
      slot[2] <= job_c;
    end else if (drain) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  `FNWS_ASSERT_NEXT(a_frame_wraps, clk, rst, accept && last_row && last_col, (row == '0) && (col == '0))
  `FNWS_ASSERT_IMPL(a_frame_end_closes_run, clk, rst, job_valid && job.frame_end, job.last_of_run)

endmodule

FILE: hdl/fnws_filter.sv
`timescale 1ns / 1ps
`include "four_neighbour_weighted_smoothing_defines.svh"

module fnws_filter
  import fnws_pkg::*;
#(
  parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [WEIGHT_W-1:0] center_weight,
  input  logic signed [WEIGHT_W-1:0] neighbour_weight,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  job_t                       job,
  input  logic [FIFO_CNT_W-1:0]      fifo_count,
  output logic                       res_valid,
  output result_t                    res
);

  // Multiplicands are at most 4 * 255 and 4 * 255, which fit 10 bits unsigned.
  localparam int OPD_W  = CHAN_W + 2;
  localparam int PROD_W = WEIGHT_W + OPD_W + 1;
  localparam int NUM_W  = PROD_W + 1;
  localparam int SHIFT  = WEIGHT_FRAC_BITS + 2;

  logic signed [PROD_W-1:0] mul_c [3];
  logic signed [PROD_W-1:0] mul_n [3];
  logic signed [PROD_W-1:0] pc    [3];
  logic signed [PROD_W-1:0] pn    [3];
  logic                     s1_valid;
  logic                     s1_last;
  logic                     s1_fend;
  logic [CHAN_W-1:0]        chan  [3];

  function automatic logic [CHAN_W-1:0] sat8(input logic signed [NUM_W-1:0] num);
    logic [NUM_W-1:0] q;
    q = unsigned'(num) >> SHIFT;
    if (num <= 0) begin
      return '0;
    end else if (|q[NUM_W-1:CHAN_W]) begin
      return {CHAN_W{1'b1}};
    end else begin
      return q[CHAN_W-1:0];
    end
  endfunction

  // Space must remain for the word in the product stage as well.
  assign job_ready = (FIFO_CNT_W'(fifo_count) + FIFO_CNT_W'(s1_valid)) < FIFO_CNT_W'(OUT_DEPTH);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [OPD_W-1:0] c4;
      logic [OPD_W-1:0] nsum;
      c4   = {job.center[CHAN_W*i +: CHAN_W], 2'b00};
      nsum = OPD_W'(job.up[CHAN_W*i +: CHAN_W]) + OPD_W'(job.down[CHAN_W*i +: CHAN_W])
           + OPD_W'(job.left[CHAN_W*i +: CHAN_W]) + OPD_W'(job.right[CHAN_W*i +: CHAN_W]);
      mul_c[i] = center_weight * $signed({1'b0, c4});
      mul_n[i] = neighbour_weight * $signed({1'b0, nsum});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= job_valid && job_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      for (int i = 0; i < 3; i++) begin
        pc[i] <= mul_c[i];
        pn[i] <= mul_n[i];
      end
      s1_last <= job.last_of_run;
      s1_fend <= job.frame_end;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chan[i] = sat8(NUM_W'(pc[i]) + NUM_W'(pn[i]));
    end
  end

  assign res_valid       = s1_valid;
  assign res.blue        = chan[0];
  assign res.green       = chan[1];
  assign res.red         = chan[2];
  assign res.last_of_run = s1_last;
  assign res.frame_end   = s1_fend;

  `FNWS_ASSERT_IMPL(a_queue_has_room, clk, rst, s1_valid, fifo_count < FIFO_CNT_W'(OUT_DEPTH))

endmodule

FILE: hdl/fnws_out_fifo.sv
`timescale 1ns / 1ps
`include "four_neighbour_weighted_smoothing_defines.svh"

module fnws_out_fifo
  import fnws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  output logic [FIFO_CNT_W-1:0] count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_data
);

  result_t               store [OUT_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(OUT_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  `FNWS_ASSERT_IMPL(a_count_bounded, clk, rst, 1'b1, count <= FIFO_CNT_W'(OUT_DEPTH))

endmodule

FILE: hdl/four_neighbour_weighted_smoothing.sv
`timescale 1ns / 1ps

// Four-neighbour weighted smoothing of an RGB pixel stream in raster order.
// Each result channel is center_weight * centre plus neighbour_weight times the
// mean of the up, down, left and right pixels, with both weights signed Q4.12
// (WEIGHT_FRAC_BITS fraction bits); pixels past the image border are replaced
// by the nearest pixel of the same row or column. The exact value is truncated
// toward zero and saturated to 0..255. Result (r,c) is sent once pixel (r+1,c)
// has come in; on the final row result (r,c) follows pixel (r,c+1), and the
// final pixel also sends its own result, so one input word gives zero to three
// output words. m_tlast marks the last result caused by an input word and
// m_tuser[0] marks the result for the final pixel of the image. The block takes
// one pixel per clock unless results still wait in the window, as on the final
// row with two results per pixel; the master port sends one result per clock
// while m_tready is high. Each result passes from the pixel that completes its
// neighbourhood through input register and window selection, one multiplier
// stage and saturation into a four-word output queue. Two line stores of
// MAX_WIDTH words hold the previous two rows; frame_width and frame_height are
// read as at least 1, and frame_width above MAX_WIDTH acts as MAX_WIDTH.
// Registers are written through the configuration channel, which is always
// ready, and must only be changed while no results are outstanding.
module four_neighbour_weighted_smoothing
  import fnws_pkg::*;
#(
  parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
  parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [PIX_W-1:0]       s_tdata,   // in_blue, in_green, in_red
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [PIX_W-1:0]       m_tdata,   // out_blue, out_green, out_red
  output logic                   m_tlast,   // last_of_run
  output logic [0:0]             m_tuser    // frame_end
);

  cfg_t                  cfg;
  logic                  job_valid;
  logic                  job_ready;
  job_t                  job;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic                  res_valid;
  result_t               res;
  result_t               out_word;

  // Register writes are taken in any cycle; indexes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width      <= RST_FRAME_WIDTH;
      cfg.frame_height     <= RST_FRAME_HEIGHT;
      cfg.center_weight    <= RST_CENTER_WEIGHT;
      cfg.neighbour_weight <= RST_NEIGHBOUR_WEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          cfg.frame_width <= cfg_data[FRAME_WIDTH_W-1:0];
        end
        REG_FRAME_HEIGHT: begin
          cfg.frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        end
        REG_CENTER_WEIGHT: begin
          cfg.center_weight <= cfg_data[WEIGHT_W-1:0];
        end
        REG_NEIGHBOUR_WEIGHT: begin
          cfg.neighbour_weight <= cfg_data[WEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Line stores, counters and selection of the stencil for each result.
  fnws_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (cfg.frame_width),
    .frame_height (cfg.frame_height),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job)
  );

  // Weighted sum, truncation, saturation; one result per clock with queue room.
  fnws_filter #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_filter (
    .clk              (clk),
    .rst              (rst),
    .center_weight    ($signed(cfg.center_weight)),
    .neighbour_weight ($signed(cfg.neighbour_weight)),
    .job_valid        (job_valid),
    .job_ready        (job_ready),
    .job              (job),
    .fifo_count       (fifo_count),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Output queue decouples the master port from the pipeline.
  fnws_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .count     (fifo_count),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_word)
  );

  assign m_tdata    = {out_word.red, out_word.green, out_word.blue};
  assign m_tlast    = out_word.last_of_run;
  assign m_tuser[0] = out_word.frame_end;

endmodule

FILE: tb/four_neighbour_weighted_smoothing_tb.sv
`timescale 1ns / 1ps

module four_neighbour_weighted_smoothing_tb;
  import fnws_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RANDOM_PIXELS = 280;
  // Window and filter pipeline plus the output queue; this many quiet cycles
  // after the last result lets the block settle before a register write.
  localparam int IDLE_GAP      = 8;
  localparam int LIMIT_CYCLES  = 5_000_000;
  localparam int MAX_REPORTS   = 40;
  localparam int ROUND_SHIFT   = DEF_WEIGHT_FRAC_BITS + 2;

  // Register indexes past the end of the map; the block must ignore them.
  localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX_LOW  = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX_HIGH = '1;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [PIX_W-1:0]       s_tdata   = '0;  // in_blue, in_green, in_red
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [PIX_W-1:0]       m_tdata;         // out_blue, out_green, out_red
  logic                   m_tlast;         // last_of_run
  logic [0:0]             m_tuser;         // frame_end

  four_neighbour_weighted_smoothing DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #(CLK_HALF) clk = ~clk;

  // Shadow copy of the block's registers, as seen by the smoothing predictor.
  logic [FRAME_WIDTH_W-1:0]  width_reg  = RST_FRAME_WIDTH;
  logic [FRAME_HEIGHT_W-1:0] height_reg = RST_FRAME_HEIGHT;
  logic signed [WEIGHT_W-1:0] center_w  = RST_CENTER_WEIGHT;
  logic signed [WEIGHT_W-1:0] edge_w    = RST_NEIGHBOUR_WEIGHT;

  // Shadow line stores and raster position. Entries start unknown, but the
  // stimulus only ever runs whole frames, so nothing unwritten is ever used.
  pix_t        upper_line [DEF_MAX_WIDTH];
  pix_t        middle_line[DEF_MAX_WIDTH];
  int unsigned col_pos  = 0;
  int unsigned row_pos  = 0;
  pix_t        left_prev = '0;

  // Smoothed words still owed by the block, oldest first.
  result_t     smoothed_words[$];

  // Both sides of the stream pace themselves only while these are set.
  bit          src_pacing = 1'b1;
  bit          sink_pacing = 1'b1;
  int unsigned hold_cnt = 0;

  int unsigned mismatch_count = 0;
  int unsigned words_checked  = 0;
  int unsigned pixels_sent    = 0;
  int unsigned frames_run     = 0;
  int unsigned cycle_count    = 0;

  // ---------------------------------------------------------------------------
  // Smoothing predictor
  // ---------------------------------------------------------------------------

  // One channel: (4 * cw * centre + nw * sum of four neighbours) / 4, kept in
  // Q4.12 and then truncated toward zero and clamped into a byte.
  function automatic logic [CHAN_W-1:0] smooth_channel(pix_t ce, pix_t up, pix_t dn,
                                                       pix_t lf, pix_t rt, int sh);
    longint centre;
    longint ring;
    longint acc;
    centre = longint'(ce[sh +: CHAN_W]);
    ring   = longint'(up[sh +: CHAN_W]) + longint'(dn[sh +: CHAN_W])
           + longint'(lf[sh +: CHAN_W]) + longint'(rt[sh +: CHAN_W]);
    acc    = longint'(center_w) * centre * 4 + longint'(edge_w) * ring;
    if (acc <= 0) return '0;
    acc = acc >>> ROUND_SHIFT;
    if (acc > 255) return '1;
    return acc[CHAN_W-1:0];
  endfunction

  function automatic result_t smooth_word(pix_t ce, pix_t up, pix_t dn, pix_t lf,
                                          pix_t rt, logic fend);
    result_t w;
    w.blue        = smooth_channel(ce, up, dn, lf, rt, 0);
    w.green       = smooth_channel(ce, up, dn, lf, rt, CHAN_W);
    w.red         = smooth_channel(ce, up, dn, lf, rt, 2 * CHAN_W);
    w.last_of_run = 1'b0;
    w.frame_end   = fend;
    return w;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // Advances the shadow raster by one accepted pixel and queues every word it
  // completes: the pixel above it once the row below has reached it, and on
  // the final row the pixel to its left plus, at the row's end, itself.
  task automatic predict_pixel(pix_t pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned cr;
    int          n;
    bit          last_row;
    bit          last_col;
    pix_t        old_mid;
    pix_t        up;
    pix_t        lf;
    pix_t        ce;
    result_t     batch[3];
    w = eff_width();
    h = eff_height();
    c = (col_pos >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col_pos;
    r = row_pos;
    n = 0;
    last_row = (r + 1 >= h);
    last_col = (c + 1 >= w);
    cr = last_col ? c : c + 1;

    old_mid = middle_line[c];
    if (r >= 1) begin
      // The row above the middle row is clamped to the middle row itself on
      // row one, and the left neighbour to the centre in column zero.
      up = (r >= 2) ? upper_line[c] : old_mid;
      lf = (c > 0) ? left_prev : old_mid;
      batch[n] = smooth_word(old_mid, up, pix, lf, middle_line[cr], 1'b0);
      n++;
    end

    left_prev      = old_mid;
    upper_line[c]  = old_mid;
    middle_line[c] = pix;

    if (last_row) begin
      // On the final row there is no row below, so the centre stands in for it.
      if (c >= 1) begin
        ce = middle_line[c - 1];
        lf = (c >= 2) ? middle_line[c - 2] : ce;
        up = (r >= 1) ? upper_line[c - 1] : ce;
        batch[n] = smooth_word(ce, up, ce, lf, pix, 1'b0);
        n++;
      end
      if (last_col) begin
        lf = (c >= 1) ? middle_line[c - 1] : pix;
        up = (r >= 1) ? upper_line[c] : pix;
        batch[n] = smooth_word(pix, up, pix, lf, pix, 1'b1);
        n++;
      end
    end

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      col_pos = c + 1;
    end

    if (n > 0) batch[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) smoothed_words.push_back(batch[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Writes one register and mirrors it into the shadow copy. The channel is
  // left valid so that writes can run back to back; callers lower it.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:      width_reg  = data[FRAME_WIDTH_W-1:0];
      REG_FRAME_HEIGHT:     height_reg = data[FRAME_HEIGHT_W-1:0];
      REG_CENTER_WEIGHT:    center_w   = data;
      REG_NEIGHBOUR_WEIGHT: edge_w     = data;
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] cw, logic [CFG_DATA_W-1:0] nw);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CENTER_WEIGHT, cw);
    write_reg(REG_NEIGHBOUR_WEIGHT, nw);
    cfg_valid <= 1'b0;
  endtask

  // Sends one pixel word after a random gap. Valid is only lowered for a gap,
  // so back-to-back words keep it high between them.
  task automatic send_pixel(pix_t pix);
    int unsigned gap;
    gap = src_pacing ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(pix);
    pixels_sent++;
  endtask

  // Stops the pixel stream and lets every owed word come out, then leaves
  // the block quiet long enough to accept register writes.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (smoothed_words.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
    frames_run++;
  endtask

  // Random pixel with each channel pinned to black or white now and then.
  function automatic pix_t random_pixel();
    pix_t p;
    p = pix_t'($urandom);
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0: p[k*CHAN_W +: CHAN_W] = '0;
        1: p[k*CHAN_W +: CHAN_W] = '1;
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic send_random_frame();
    int unsigned count;
    count = eff_width() * eff_height();
    for (int unsigned i = 0; i < count; i++) send_pixel(random_pixel());
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    // Only the first few are printed; the count still covers all of them.
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH at word %0d: %s", words_checked, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic check_word();
    result_t want;
    if (smoothed_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h", m_tdata));
    end else begin
      want = smoothed_words.pop_front();
      check_field("out_blue",    m_tdata[0 +: CHAN_W],          want.blue);
      check_field("out_green",   m_tdata[CHAN_W +: CHAN_W],     want.green);
      check_field("out_red",     m_tdata[2*CHAN_W +: CHAN_W],   want.red);
      check_field("last_of_run", m_tlast,                       want.last_of_run);
      check_field("frame_end",   m_tuser[0],                    want.frame_end);
    end
    words_checked++;
  endtask

  // Checks each accepted word, then holds ready low for a random stretch.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      check_word();
      hold_cnt = sink_pacing ? $urandom_range(0, 3) : 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
    end
    m_tready <= !rst && (hold_cnt == 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d words still owed.",
               cycle_count, smoothed_words.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Only the width is written, so height and both weights keep their reset
  // values: a single row passed through unchanged.
  task automatic test_reset_weights();
    write_reg(REG_FRAME_WIDTH, 16'd4);
    cfg_valid <= 1'b0;
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h00FF00);
    send_pixel(24'hA5015A);
    wait_idle();
  endtask

  // Width and height of zero act as one, width data bits above the register
  // are dropped, and writes past the register map change nothing.
  task automatic test_degenerate_sizes();
    write_reg(REG_FRAME_WIDTH, 16'hF800);
    write_reg(REG_FRAME_HEIGHT, 16'h0000);
    write_reg(REG_CENTER_WEIGHT, 16'h7FFF);
    write_reg(REG_NEIGHBOUR_WEIGHT, 16'h7FFF);
    write_reg(UNMAPPED_INDEX_LOW, 16'h0005);
    write_reg(UNMAPPED_INDEX_HIGH, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_pixel(24'hFF7F01);
    wait_idle();
  endtask

  // A one-pixel-wide image clamps left and right to the centre, and a strongly
  // negative centre weight drives results to zero unless the ring outweighs it.
  task automatic test_single_column();
    configure(16'd1, 16'd3, 16'h8000, 16'h7FFF);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h80FF00);
    wait_idle();
  endtask

  // Sharpening on a 3x3 checkerboard, then both weights at opposite extremes.
  task automatic test_weight_extremes();
    configure(16'd3, 16'd3, 16'h2000, 16'hF000);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000);
    wait_idle();
    configure(16'd2, 16'd2, 16'h7FFF, 16'h8000);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel());
    wait_idle();
  endtask

  // The widest register value acts as the full line store, in a single row.
  task automatic test_wide_row();
    configure(16'h07FF, 16'd1, 16'h0800, 16'h0800);
    send_random_frame();
  endtask

  // The tallest image in a single column walks the row counter to its top.
  task automatic test_tall_column();
    src_pacing = 1'b0;
    configure(16'd1, 16'hFFFF, 16'h0C00, 16'h0400);
    send_random_frame();
    src_pacing = 1'b1;
  endtask

  // Mostly small images with random weights; each side runs at full rate in
  // one frame in four, chosen independently of the other side.
  task automatic test_random_frames();
    int unsigned start;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    logic [CFG_DATA_W-1:0] cw;
    logic [CFG_DATA_W-1:0] nw;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1);
        1, 2:    w = $urandom_range(7, 24);
        default: w = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0:       h = $urandom_range(0, 1);
        1:       h = $urandom_range(6, 10);
        default: h = $urandom_range(2, 5);
      endcase
      if ($urandom_range(0, 2) == 0) begin
        cw = $urandom;
        nw = $urandom;
      end else begin
        cw = $urandom_range(0, 16'h1400);
        nw = 16'($urandom_range(0, 16'h2000)) - 16'h1000;
      end
      src_pacing  = ($urandom_range(0, 3) != 0);
      sink_pacing = ($urandom_range(0, 3) != 0);
      configure(w, h, cw, nw);
      send_random_frame();
    end
    src_pacing  = 1'b1;
    sink_pacing = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_weights();
    test_degenerate_sizes();
    test_single_column();
    test_weight_extremes();
    test_random_frames();
    test_wide_row();
    test_tall_column();

    wait_idle();
    $display("Ran %0d frames: %0d pixels sent, %0d smoothed words checked, %0d mismatches.",
             frames_run - 1, pixels_sent, words_checked, mismatch_count);
    $display("Sizes ranged from 1x1 to a full-width row and a 65535-row column.");
    if (mismatch_count == 0 && smoothed_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
